[hw/rtl/rsmp_pkg.sv]
// Shared types and constants for the linear interpolation resampler.
// Depends on nothing; the interfaces, front, back and top use it by scoped names.
package rsmp_pkg;

	localparam int SAMPLE_W    = 24;  // Q1.23 sample
	localparam int INDEX_W     = 13;  // output index field
	localparam int COUNT_IN_W  = 14;  // output count field, also the divisor width
	localparam int CMD_W       = 3;
	localparam int FRAC_QW     = 24;  // quotient bits for the fraction division
	localparam int QUEUE_DEPTH = 4;

	// Queue entry without the frame position field, whose width follows the store depth
	localparam int ENTRY_FIX_W = CMD_W + SAMPLE_W + INDEX_W + COUNT_IN_W;

	typedef enum logic [1:0] {
		OP_NEW_FRAME = 2'd0,
		OP_APPEND    = 2'd1,
		OP_EMIT      = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_BAD_INDEX = 2'd2
	} status_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE,
		CMD_EMPTY,
		CMD_BAD_INDEX,
		CMD_SINGLE,
		CMD_INTERP
	} cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_POS,
		BK_POS_WAIT,
		BK_READ,
		BK_FETCH,
		BK_FRAC,
		BK_FRAC_WAIT,
		BK_DONE
	} back_state_t;

endpackage

[hw/rtl/rsmp_if.sv]
// Request and result channel interfaces of the resampler.
// Depends on rsmp_pkg for the field widths.
interface rsmp_in_if;
	logic                                   valid;
	logic                                   ready;
	logic [1:0]                             opcode;
	logic signed [rsmp_pkg::SAMPLE_W-1:0]   sample_in;
	logic [rsmp_pkg::INDEX_W-1:0]           out_index;
	logic [rsmp_pkg::COUNT_IN_W-1:0]        out_count;

	modport source(output valid, opcode, sample_in, out_index, out_count, input ready);
	modport sink(input valid, opcode, sample_in, out_index, out_count, output ready);
endinterface

interface rsmp_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [rsmp_pkg::SAMPLE_W-1:0]   sample_out;
	logic [1:0]                             status;

	modport source(output valid, sample_out, status, input ready);
	modport sink(input valid, sample_out, status, output ready);
endinterface

[hw/rtl/rsmp_div.sv]
// Restoring divider, one quotient bit per cycle, for quotients known to fit QW bits.
// Standalone; used by rsmp_back for both the position and the fraction division.
module rsmp_div #(
	parameter int QW    = 24,
	parameter int DVS_W = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [QW+DVS_W-1:0]   dividend,
	input  logic [DVS_W-1:0]      divisor,
	output logic                  done,
	output logic [QW-1:0]         quotient,
	output logic [DVS_W-1:0]      remainder
);

	localparam int DW    = QW + DVS_W;
	localparam int CNT_W = $clog2(QW);

	logic [DVS_W-1:0] rem_q;
	logic [QW-1:0]    quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic           fits;

	assign trial = {rem_q, quo_q[QW-1]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// High part of the dividend stays below the divisor, so it seeds the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[DW-1:QW];
			quo_q <= dividend[QW-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[QW-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[hw/rtl/rsmp_fifo.sv]
// Short command queue between the front and the back of the resampler.
// Standalone register queue; no package use.
module rsmp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = cnt_q == CNT_W'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

[hw/rtl/rsmp_front.sv]
// Front end: takes requests, tracks the frame fill level and classifies each request.
// Depends on rsmp_pkg and rsmp_in_if; feeds rsmp_fifo.
module rsmp_front #(
	parameter int SRC_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	rsmp_in_if.sink     in_ch,
	output logic        push,
	output logic [rsmp_pkg::ENTRY_FIX_W+$clog2(SRC_DEPTH+1)-1:0] entry,
	input  logic        full
);

	localparam int CNT_W = $clog2(SRC_DEPTH + 1);

	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     count_d;
	logic [CNT_W-1:0]     arg;
	rsmp_pkg::cmd_t       kind;
	logic                 accept;

	assign in_ch.ready = !full;
	assign accept      = in_ch.valid && in_ch.ready;

	always_comb begin
		push    = 1'b0;
		kind    = rsmp_pkg::CMD_WRITE;
		arg     = '0;
		count_d = count_q;
		unique case (in_ch.opcode)
			rsmp_pkg::OP_NEW_FRAME: begin
				push = accept;
				if (accept) begin
					count_d = CNT_W'(1);
				end
			end
			rsmp_pkg::OP_APPEND: begin
				// drop appends once the store is full
				if (count_q != CNT_W'(SRC_DEPTH)) begin
					push = accept;
					arg  = count_q;
					if (accept) begin
						count_d = count_q + CNT_W'(1);
					end
				end
			end
			rsmp_pkg::OP_EMIT: begin
				push = accept;
				arg  = count_q;
				if (count_q == '0) begin
					kind = rsmp_pkg::CMD_EMPTY;
				end else if ({1'b0, in_ch.out_index} >= in_ch.out_count) begin
					kind = rsmp_pkg::CMD_BAD_INDEX;
				end else if (count_q == CNT_W'(1)) begin
					kind = rsmp_pkg::CMD_SINGLE;
				end else begin
					kind = rsmp_pkg::CMD_INTERP;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	assign entry = {kind, in_ch.sample_in, in_ch.out_index, in_ch.out_count, arg};

endmodule

[hw/rtl/rsmp_back.sv]
// Back end: writes the sample store and computes interpolated results in order.
// Depends on rsmp_pkg, rsmp_out_if and rsmp_div; drains rsmp_fifo.
module rsmp_back #(
	parameter int SRC_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        empty,
	output logic        pop,
	input  logic [rsmp_pkg::ENTRY_FIX_W+$clog2(SRC_DEPTH+1)-1:0] entry,
	rsmp_out_if.source  out_ch
);

	localparam int SAMPLE_W = rsmp_pkg::SAMPLE_W;
	localparam int INDEX_W  = rsmp_pkg::INDEX_W;
	localparam int CNT_W    = $clog2(SRC_DEPTH + 1);
	localparam int IDX_W    = $clog2(SRC_DEPTH);
	localparam int ENTRY_W  = rsmp_pkg::ENTRY_FIX_W + CNT_W;
	localparam int DVS_W    = rsmp_pkg::COUNT_IN_W;
	localparam int QW       = (CNT_W > rsmp_pkg::FRAC_QW) ? CNT_W : rsmp_pkg::FRAC_QW;
	localparam int DW       = QW + DVS_W;
	localparam int NUM_W    = INDEX_W + CNT_W;
	localparam int DIFF_W   = SAMPLE_W + 1;
	localparam int PROD_W   = DIFF_W + DVS_W;
	localparam int MAG_W    = PROD_W - 1;
	localparam int STEP_W   = SAMPLE_W + 1;
	localparam int SUM_W    = SAMPLE_W + 2;

	// entry fields
	rsmp_pkg::cmd_t              e_kind;
	logic signed [SAMPLE_W-1:0]  e_sample;
	logic [INDEX_W-1:0]          e_k;
	logic [DVS_W-1:0]            e_m;
	logic [CNT_W-1:0]            e_arg;

	assign e_kind   = rsmp_pkg::cmd_t'(entry[ENTRY_W-1 -: rsmp_pkg::CMD_W]);
	assign e_sample = entry[CNT_W+DVS_W+INDEX_W +: SAMPLE_W];
	assign e_k      = entry[CNT_W+DVS_W +: INDEX_W];
	assign e_m      = entry[CNT_W +: DVS_W];
	assign e_arg    = entry[CNT_W-1:0];

	rsmp_pkg::back_state_t state_q;
	rsmp_pkg::back_state_t state_d;

	logic                        mem_we;
	logic                        rd_en;
	logic                        div_start;
	logic                        out_load;

	logic [SAMPLE_W-1:0]         mem [SRC_DEPTH];
	logic signed [SAMPLE_W-1:0]  rd_a_q;
	logic signed [SAMPLE_W-1:0]  rd_b_q;

	logic [NUM_W-1:0]            num_q;
	logic [DVS_W-1:0]            m_q;
	logic [CNT_W-1:0]            n_q;
	logic [IDX_W-1:0]            l_q;
	logic [DVS_W-1:0]            rem_q;
	logic                        single_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [SAMPLE_W-1:0]  res_sample_q;
	rsmp_pkg::status_t           res_status_q;

	logic                        out_valid_q;
	logic signed [SAMPLE_W-1:0]  out_sample_q;
	rsmp_pkg::status_t           out_status_q;

	logic [DW-1:0]               div_dividend;
	logic                        div_done;
	logic [QW-1:0]               div_quo;
	logic [DVS_W-1:0]            div_rem;

	logic [PROD_W-1:0]           prod_abs;
	logic [MAG_W-1:0]            prod_mag;
	logic                        prod_neg;
	logic [QW:0]                 quo_p1;
	logic [QW-1:0]               l_pick;
	logic signed [DIFF_W-1:0]    diff;
	logic signed [DVS_W:0]       rem_s;
	logic signed [PROD_W-1:0]    prod_d;
	logic [STEP_W-1:0]           step;
	logic signed [SUM_W-1:0]     a_ext;
	logic signed [SUM_W-1:0]     step_ext;
	logic signed [SUM_W-1:0]     val;

	rsmp_div #(
		.QW    (QW),
		.DVS_W (DVS_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (m_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rsmp_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		mem_we    = 1'b0;
		rd_en     = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			rsmp_pkg::BK_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					unique case (e_kind)
						rsmp_pkg::CMD_WRITE:     mem_we  = 1'b1;
						rsmp_pkg::CMD_EMPTY:     state_d = rsmp_pkg::BK_DONE;
						rsmp_pkg::CMD_BAD_INDEX: state_d = rsmp_pkg::BK_DONE;
						rsmp_pkg::CMD_SINGLE:    state_d = rsmp_pkg::BK_READ;
						rsmp_pkg::CMD_INTERP:    state_d = rsmp_pkg::BK_POS;
						default: begin
						end
					endcase
				end
			end
			rsmp_pkg::BK_POS: begin
				div_start = 1'b1;
				state_d   = rsmp_pkg::BK_POS_WAIT;
			end
			rsmp_pkg::BK_POS_WAIT: begin
				if (div_done) begin
					state_d = rsmp_pkg::BK_READ;
				end
			end
			rsmp_pkg::BK_READ: begin
				rd_en   = 1'b1;
				state_d = rsmp_pkg::BK_FETCH;
			end
			rsmp_pkg::BK_FETCH: begin
				state_d = single_q ? rsmp_pkg::BK_DONE : rsmp_pkg::BK_FRAC;
			end
			rsmp_pkg::BK_FRAC: begin
				div_start = 1'b1;
				state_d   = rsmp_pkg::BK_FRAC_WAIT;
			end
			rsmp_pkg::BK_FRAC_WAIT: begin
				if (div_done) begin
					state_d = rsmp_pkg::BK_DONE;
				end
			end
			rsmp_pkg::BK_DONE: begin
				// hold the result until the output register is free
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = rsmp_pkg::BK_IDLE;
				end
			end
		endcase
	end

	// Floor division of a signed product: divide the magnitude, then round away for negatives
	assign prod_neg     = prod_q[PROD_W-1];
	assign prod_abs     = prod_neg ? -prod_q : prod_q;
	assign prod_mag     = prod_abs[MAG_W-1:0];
	assign div_dividend = (state_q == rsmp_pkg::BK_POS) ? DW'(num_q) : DW'(prod_mag);

	assign quo_p1 = {1'b0, div_quo} + (QW+1)'(1);
	assign l_pick = (quo_p1 >= (QW+1)'(n_q)) ? QW'(n_q - CNT_W'(2)) : div_quo;

	assign diff   = DIFF_W'(rd_b_q) - DIFF_W'(rd_a_q);
	assign rem_s  = $signed({1'b0, rem_q});
	assign prod_d = PROD_W'(diff) * PROD_W'(rem_s);

	assign step     = STEP_W'(div_quo) + STEP_W'(prod_neg && (div_rem != '0));
	assign a_ext    = SUM_W'(rd_a_q);
	assign step_ext = $signed(SUM_W'(step));
	assign val      = prod_neg ? (a_ext - step_ext) : (a_ext + step_ext);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[e_arg[IDX_W-1:0]] <= e_sample;
		end
		if (rd_en) begin
			rd_a_q <= mem[l_q];
			rd_b_q <= mem[l_q + IDX_W'(1)];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rsmp_pkg::BK_IDLE && pop) begin
			unique case (e_kind)
				rsmp_pkg::CMD_EMPTY: begin
					res_sample_q <= '0;
					res_status_q <= rsmp_pkg::STAT_EMPTY;
				end
				rsmp_pkg::CMD_BAD_INDEX: begin
					res_sample_q <= '0;
					res_status_q <= rsmp_pkg::STAT_BAD_INDEX;
				end
				rsmp_pkg::CMD_SINGLE: begin
					l_q      <= '0;
					single_q <= 1'b1;
				end
				rsmp_pkg::CMD_INTERP: begin
					num_q    <= NUM_W'(e_k) * NUM_W'(e_arg - CNT_W'(1));
					m_q      <= e_m;
					n_q      <= e_arg;
					single_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
		if (state_q == rsmp_pkg::BK_POS_WAIT && div_done) begin
			l_q   <= l_pick[IDX_W-1:0];
			rem_q <= div_rem;
		end
		if (state_q == rsmp_pkg::BK_FETCH) begin
			if (single_q) begin
				res_sample_q <= rd_a_q;
				res_status_q <= rsmp_pkg::STAT_OK;
			end else begin
				prod_q <= prod_d;
			end
		end
		if (state_q == rsmp_pkg::BK_FRAC_WAIT && div_done) begin
			res_sample_q <= val[SAMPLE_W-1:0];
			res_status_q <= rsmp_pkg::STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= res_sample_q;
			out_status_q <= res_status_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_sample_q;
	assign out_ch.status     = out_status_q;

endmodule

[hw/rtl/linear_interp_resampler_core.sv]
// Linear interpolation resampler for one audio channel frame, top level.
// Depends on rsmp_pkg, rsmp_if, rsmp_front, rsmp_fifo and rsmp_back.
//
// in_ch carries requests: new-frame and append loads with a Q1.23 sample, and
// emit requests with an output index and count. Loads give no result; each
// emit gives one result on out_ch: the interpolated sample and a status code
// (empty frame or index not below count, sample zero in both cases).
// Requests are taken whenever the four-entry queue between front and back
// has room, so several requests may be accepted while one is in work.
// In the back, a load only writes the sample store; an emit that fails a check goes
// straight to the output register and one on a single-sample frame reads the store
// first; an interpolated emit runs the shared one-bit-per-cycle divider (quotient
// width QW being 24 or the count width if wider) once for the source position and
// once for the fraction. Reset clears the frame count and the queue; the sample
// store is not cleared and only its entries below the count are used. When out_ch
// stalls, the finished result waits in the output register, the back holds its
// next result, and in_ch keeps accepting until the queue fills.
module linear_interp_resampler_core #(
	parameter int SRC_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	rsmp_in_if.sink     in_ch,
	rsmp_out_if.source  out_ch
);

	localparam int CNT_W   = $clog2(SRC_DEPTH + 1);
	localparam int ENTRY_W = rsmp_pkg::ENTRY_FIX_W + CNT_W;

	logic               push;
	logic               full;
	logic               pop;
	logic               empty;
	logic [ENTRY_W-1:0] push_data;
	logic [ENTRY_W-1:0] pop_data;

	rsmp_front #(
		.SRC_DEPTH (SRC_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.push   (push),
		.entry  (push_data),
		.full   (full)
	);

	rsmp_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (rsmp_pkg::QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	rsmp_back #(
		.SRC_DEPTH (SRC_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.pop    (pop),
		.entry  (pop_data),
		.out_ch (out_ch)
	);

`ifndef SYNTHESIS
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue push while full");

	a_pop_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue pop while empty");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.status != rsmp_pkg::STAT_OK) |-> out_ch.sample_out == '0)
		else $error("error result with nonzero sample");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for linear_interp_resampler_core: frame loads and emit requests.
// Depends on rsmp_pkg, rsmp_if and the core; expected samples come from an in-bench predictor.
`timescale 1ns / 1ps

module testbench;

	localparam int DEPTH       = 1024;
	localparam int RAND_ITEMS  = 1950;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 80;

	localparam logic [1:0] OP_RESERVED = 2'd3;

	typedef struct {
		logic signed [rsmp_pkg::SAMPLE_W-1:0] sample;
		rsmp_pkg::status_t                    status;
	} interp_result_t;

	// Tracks the stored frame and the interpolated samples still owed by the block.
	class frame_predictor;
		int             frame_mem[DEPTH];
		int             frame_len;
		interp_result_t owed[$];
		int             mismatches;

		function new();
			foreach (frame_mem[i])
				frame_mem[i] = 0;
			frame_len  = 0;
			mismatches = 0;
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function interp_result_t interpolate(logic [rsmp_pkg::INDEX_W-1:0] k,
				logic [rsmp_pkg::COUNT_IN_W-1:0] m);
			interp_result_t r;
			longint num, whole, rem, a, b, prod, q;
			r.sample = '0;
			r.status = rsmp_pkg::STAT_OK;
			if (frame_len == 0) begin
				r.status = rsmp_pkg::STAT_EMPTY;
				return r;
			end
			if (k >= m) begin
				r.status = rsmp_pkg::STAT_BAD_INDEX;
				return r;
			end
			if (frame_len == 1) begin
				r.sample = rsmp_pkg::SAMPLE_W'(frame_mem[0]);
				return r;
			end
			num   = longint'(k) * longint'(frame_len - 1);
			whole = num / longint'(m);
			rem   = num % longint'(m);
			if (whole + 1 >= frame_len)
				whole = frame_len - 2;
			a    = frame_mem[whole];
			b    = frame_mem[whole + 1];
			prod = (b - a) * rem;
			q    = prod / longint'(m);
			// round toward minus infinity
			if ((prod % longint'(m)) != 0 && prod < 0)
				q = q - 1;
			r.sample = rsmp_pkg::SAMPLE_W'(a + q);
			return r;
		endfunction

		function void note_request(logic [1:0] op, logic signed [rsmp_pkg::SAMPLE_W-1:0] s,
				logic [rsmp_pkg::INDEX_W-1:0] k, logic [rsmp_pkg::COUNT_IN_W-1:0] m);
			case (op)
				rsmp_pkg::OP_NEW_FRAME: begin
					frame_mem[0] = int'(s);
					frame_len    = 1;
				end
				rsmp_pkg::OP_APPEND: begin
					if (frame_len < DEPTH) begin
						frame_mem[frame_len] = int'(s);
						frame_len++;
					end
				end
				rsmp_pkg::OP_EMIT: begin
					owed.push_back(interpolate(k, m));
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic signed [rsmp_pkg::SAMPLE_W-1:0] s, logic [1:0] st);
			interp_result_t e;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result sample=%h status=%0d", $realtime, s, st);
				return;
			end
			e = owed.pop_front();
			if (s !== e.sample || st !== e.status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: mismatch sample exp=%h got=%h status exp=%0d got=%0d",
						$realtime, e.sample, s, e.status, st);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rsmp_in_if  in_ch();
	rsmp_out_if out_ch();

	linear_interp_resampler_core #(.SRC_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	frame_predictor pred;
	bit  no_idle;
	bit  hold_request;
	int  items_sent;
	int  stall_cycles;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Called right after a rising edge; returns right after the edge that accepts the request.
	task automatic send_request(input logic [1:0] op,
			input logic signed [rsmp_pkg::SAMPLE_W-1:0] s,
			input logic [rsmp_pkg::INDEX_W-1:0] k, input logic [rsmp_pkg::COUNT_IN_W-1:0] m);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.opcode    <= op;
		in_ch.sample_in <= s;
		in_ch.out_index <= k;
		in_ch.out_count <= m;
		do
			@(posedge clk);
		while (!in_ch.ready);
		pred.note_request(op, s, k, m);
		if (op != OP_RESERVED)
			items_sent++;
	endtask

	function automatic logic signed [rsmp_pkg::SAMPLE_W-1:0] draw_sample();
		case ($urandom_range(0, 9))
			0:       return 24'h7FFFFF;
			1:       return 24'h800000;
			2:       return rsmp_pkg::SAMPLE_W'($urandom_range(0, 15)) - 24'sd8;
			default: return rsmp_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic send_load(input logic [1:0] op);
		send_request(op, draw_sample(), rsmp_pkg::INDEX_W'($urandom),
			rsmp_pkg::COUNT_IN_W'($urandom));
	endtask

	task automatic send_emit();
		int m, k;
		case ($urandom_range(0, 9))
			0, 1, 2: m = $urandom_range(1, 16);
			3:       m = $urandom_range(0, 16383);
			4:       m = 8192;
			default: m = $urandom_range(1, 8192);
		endcase
		if (m > 8192)
			k = $urandom_range(0, 8191);
		else if (m == 0 || $urandom_range(0, 9) == 0)
			k = $urandom_range(m > 8191 ? 8191 : m, 8191);
		else
			k = $urandom_range(0, m - 1);
		send_request(rsmp_pkg::OP_EMIT, rsmp_pkg::SAMPLE_W'($urandom),
			rsmp_pkg::INDEX_W'(k), rsmp_pkg::COUNT_IN_W'(m));
	endtask

	// Always advance past one edge so the next request drives valid in a later step.
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pred.pending() != 0);
	endtask

	task automatic run_directed();
		// empty frame wins over a bad index
		send_request(rsmp_pkg::OP_EMIT, 24'h0, 13'd5, 14'd3);
		send_request(rsmp_pkg::OP_EMIT, 24'h0, 13'd0, 14'd1);
		// append on an empty frame lands in entry zero
		send_request(rsmp_pkg::OP_APPEND, 24'h7FFFFF, 13'h1FFF, 14'h3FFF);
		send_request(rsmp_pkg::OP_EMIT, 24'hFFFFFF, 13'd0, 14'd1);
		send_request(rsmp_pkg::OP_EMIT, 24'h0, 13'd8191, 14'd8192);
		send_request(OP_RESERVED, 24'hFFFFFF, 13'h1FFF, 14'h3FFF);
		send_request(rsmp_pkg::OP_NEW_FRAME, 24'h800000, 13'd0, 14'd0);
		send_request(rsmp_pkg::OP_APPEND, 24'h7FFFFF, 13'd0, 14'd0);
		send_request(rsmp_pkg::OP_EMIT, 24'h0, 13'd1, 14'd3);
		send_request(rsmp_pkg::OP_EMIT, 24'h0, 13'd8191, 14'd8192);
		send_request(rsmp_pkg::OP_EMIT, 24'h0, 13'd0, 14'd0);
		send_request(rsmp_pkg::OP_EMIT, 24'h0, 13'd8191, 14'd8191);
		send_request(rsmp_pkg::OP_EMIT, 24'h0, 13'd100, 14'd16383);
		// a falling then rising frame exercises the floor on negative products
		send_request(rsmp_pkg::OP_NEW_FRAME, 24'h7FFFFF, 13'd0, 14'd0);
		send_request(rsmp_pkg::OP_APPEND, 24'h800000, 13'd0, 14'd0);
		send_request(rsmp_pkg::OP_APPEND, 24'h000000, 13'd0, 14'd0);
		send_request(rsmp_pkg::OP_EMIT, 24'h0, 13'd1, 14'd3);
		send_request(rsmp_pkg::OP_EMIT, 24'h0, 13'd2, 14'd7);
		send_request(rsmp_pkg::OP_EMIT, 24'h0, 13'd6, 14'd7);
		send_request(rsmp_pkg::OP_APPEND, 24'hFFFFFF, 13'd0, 14'd0);
		send_request(rsmp_pkg::OP_EMIT, 24'h0, 13'd4095, 14'd4096);
		wait_drained();
	endtask

	task automatic run_frame(input int frame_no);
		int len, emits;
		if (frame_no == 10)
			len = DEPTH + $urandom_range(1, 6);  // overflow the store
		else if ($urandom_range(0, 3) == 0)
			len = $urandom_range(1, 3);
		else
			len = $urandom_range(2, 48);
		emits = $urandom_range(1, 12);
		send_load(rsmp_pkg::OP_NEW_FRAME);
		for (int i = 1; i < len; i++)
			send_load(rsmp_pkg::OP_APPEND);
		if (frame_no == 5) begin
			// stall the result side while requests keep coming
			hold_request = 1'b1;
			no_idle      = 1'b1;
			emits        = 16;
		end
		for (int i = 0; i < emits; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_request(OP_RESERVED, rsmp_pkg::SAMPLE_W'($urandom),
					rsmp_pkg::INDEX_W'($urandom), rsmp_pkg::COUNT_IN_W'($urandom));
			send_emit();
		end
	endtask

	initial begin
		pred         = new();
		arst_n       = 1'b0;
		no_idle      = 1'b0;
		hold_request = 1'b0;
		items_sent   = 0;
		in_ch.valid     <= 1'b0;
		in_ch.opcode    <= '0;
		in_ch.sample_in <= '0;
		in_ch.out_index <= '0;
		in_ch.out_count <= '0;
		out_ch.ready    <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		items_sent = 0;
		for (int f = 0; items_sent < RAND_ITEMS; f++) begin
			no_idle = ($urandom_range(0, 4) == 0);
			run_frame(f);
			if (f == 3 || $urandom_range(0, 7) == 0)
				wait_drained();
		end
		in_ch.valid <= 1'b0;
		while (pred.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pred.mismatches == 0 && pred.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request) begin
				stall        = HOLD_CYCLES;
				hold_request = 1'b0;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 7);
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_ch.valid);
			pred.check_result(out_ch.sample_out, out_ch.status);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

endmodule

[sim.f]
hw/rtl/rsmp_pkg.sv
hw/rtl/rsmp_if.sv
hw/rtl/rsmp_div.sv
hw/rtl/rsmp_fifo.sv
hw/rtl/rsmp_front.sv
hw/rtl/rsmp_back.sv
hw/rtl/linear_interp_resampler_core.sv
tb/sv/testbench.sv
